@@ hdl/xoshiro_state_transition_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the xoshiro state transition unit
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef XOSHIRO_STATE_TRANSITION_UNIT_DEFINES_SVH
`define XOSHIRO_STATE_TRANSITION_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define XST_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("xst checker: same-cycle property violated");

// Next-cycle implication, disabled while reset is high.
`define XST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("xst checker: next-cycle property violated");

`endif

@@ hdl/xst_pkg.sv @@
// ----------------------------------------------------------------------------
// xst_pkg
// Types, constants and codes shared by the xoshiro state transition unit.
// ----------------------------------------------------------------------------
`default_nettype none

package xst_pkg;

   localparam int NUM_WORDS     = 8;
   localparam int FOUR_WORDS    = 4;
   localparam int WORD_BITS     = 64;
   localparam int WIDTH_BITS    = 7;
   localparam int AMOUNT_BITS   = 6;
   localparam int INDEX_BITS    = 3;
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 7'd64;
   localparam logic                   EIGHT_RESET  = 1'b0;
   localparam logic [AMOUNT_BITS-1:0] SHIFT_RESET  = 6'd17;
   localparam logic [AMOUNT_BITS-1:0] ROTATE_RESET = 6'd45;

   typedef enum logic {
      CMD_STEP = 1'b0,
      CMD_LOAD = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      REG_WORD_WIDTH    = 2'd0,
      REG_EIGHT_WORDS   = 2'd1,
      REG_SHIFT_AMOUNT  = 2'd2,
      REG_ROTATE_AMOUNT = 2'd3
   } csr_index_type;

   typedef logic [WORD_BITS-1:0] word_type;
   typedef word_type [NUM_WORDS-1:0] words_type;

   typedef struct packed {
      logic [WIDTH_BITS-1:0]  word_width;
      logic                   eight_words;
      logic [AMOUNT_BITS-1:0] shift_amount;
      logic [AMOUNT_BITS-1:0] rotate_amount;
   } cfg_type;

endpackage

`default_nettype wire

@@ hdl/xst_csr.sv @@
// ----------------------------------------------------------------------------
// xst_csr
// Configuration registers behind a simple APB-style slave port.
// ----------------------------------------------------------------------------
`default_nettype none

module xst_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [xst_pkg::CSR_ADDR_BITS-1:0]      csr_paddr,
   input  logic [xst_pkg::CSR_DATA_BITS-1:0]      csr_pwdata,
   output logic [xst_pkg::CSR_DATA_BITS-1:0]      csr_prdata,
   output logic                                   csr_pready,
   output xst_pkg::cfg_type                       cfg
);

   xst_pkg::cfg_type       cfg_ff;
   xst_pkg::cfg_type       cfg_in;
   xst_pkg::csr_index_type reg_index;
   logic                   write_en;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_index  = xst_pkg::csr_index_type'(csr_paddr[xst_pkg::CSR_ADDR_BITS-1:2]);
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (reg_index)
            xst_pkg::REG_WORD_WIDTH: begin
               cfg_in.word_width = csr_pwdata[xst_pkg::WIDTH_BITS-1:0];
            end
            xst_pkg::REG_EIGHT_WORDS: begin
               cfg_in.eight_words = csr_pwdata[0];
            end
            xst_pkg::REG_SHIFT_AMOUNT: begin
               cfg_in.shift_amount = csr_pwdata[xst_pkg::AMOUNT_BITS-1:0];
            end
            xst_pkg::REG_ROTATE_AMOUNT: begin
               cfg_in.rotate_amount = csr_pwdata[xst_pkg::AMOUNT_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         xst_pkg::REG_WORD_WIDTH: begin
            csr_prdata = xst_pkg::CSR_DATA_BITS'(cfg_ff.word_width);
         end
         xst_pkg::REG_EIGHT_WORDS: begin
            csr_prdata = xst_pkg::CSR_DATA_BITS'(cfg_ff.eight_words);
         end
         xst_pkg::REG_SHIFT_AMOUNT: begin
            csr_prdata = xst_pkg::CSR_DATA_BITS'(cfg_ff.shift_amount);
         end
         xst_pkg::REG_ROTATE_AMOUNT: begin
            csr_prdata = xst_pkg::CSR_DATA_BITS'(cfg_ff.rotate_amount);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.word_width    <= xst_pkg::WIDTH_RESET;
         cfg_ff.eight_words   <= xst_pkg::EIGHT_RESET;
         cfg_ff.shift_amount  <= xst_pkg::SHIFT_RESET;
         cfg_ff.rotate_amount <= xst_pkg::ROTATE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/xst_update.sv @@
// ----------------------------------------------------------------------------
// xst_update
// Next-state logic: seed load or one xoshiro xor, shift and rotate step.
// ----------------------------------------------------------------------------
`default_nettype none

module xst_update (
   input  xst_pkg::cfg_type                    cfg,
   input  logic                                cmd_load,
   input  logic [xst_pkg::INDEX_BITS-1:0]      word_index,
   input  xst_pkg::word_type                   seed_word,
   input  xst_pkg::words_type                  state,
   output xst_pkg::words_type                  next_state,
   output xst_pkg::words_type                  result_words,
   output logic                                config_error
);

   localparam logic [xst_pkg::WIDTH_BITS-1:0] FULL_WIDTH =
      xst_pkg::WIDTH_BITS'(xst_pkg::WORD_BITS);

   xst_pkg::word_type                 mask;
   xst_pkg::words_type                s;
   xst_pkg::words_type                stepped;
   xst_pkg::word_type                 t;
   xst_pkg::word_type                 r2;
   xst_pkg::word_type                 r5;
   xst_pkg::word_type                 r1;
   xst_pkg::word_type                 r3;
   xst_pkg::word_type                 r7;
   xst_pkg::word_type                 r4;
   xst_pkg::word_type                 r6;
   xst_pkg::word_type                 rot_src;
   xst_pkg::word_type                 rot_out;
   logic [xst_pkg::WIDTH_BITS-1:0]    rot_back;
   logic                              shift_bad;
   logic                              rotate_bad;

   // Mask saturates at the full word; a width of zero masks everything.
   assign mask = (cfg.word_width >= FULL_WIDTH) ? '1 :
                 ((xst_pkg::WORD_BITS'(1) << cfg.word_width) - xst_pkg::WORD_BITS'(1));

   assign shift_bad  = (cfg.shift_amount == '0) ||
                       ({1'b0, cfg.shift_amount} >= cfg.word_width);
   assign rotate_bad = (cfg.rotate_amount == '0) ||
                       ({1'b0, cfg.rotate_amount} >= cfg.word_width);
   assign config_error = (cfg.word_width == '0) || (cfg.word_width > FULL_WIDTH) ||
                         shift_bad || rotate_bad;

   always_comb begin
      for (int i = 0; i < xst_pkg::NUM_WORDS; i++) begin
         s[i] = state[i] & mask;
      end
   end

   assign t = (s[1] << cfg.shift_amount) & mask;

   // Shared intermediate xors; the xor for word three differs between the two modes.
   always_comb begin
      r2 = s[2] ^ s[0];
      r5 = s[5] ^ s[1];
      r1 = s[1] ^ r2;
      r3 = cfg.eight_words ? (s[3] ^ s[4]) : (s[3] ^ s[1]);
      r7 = s[7] ^ s[3];
      r4 = s[4] ^ r5;
      r6 = s[6] ^ r7;
   end

   // The rotation is only meaningful when the configuration is valid.
   assign rot_src  = cfg.eight_words ? r7 : r3;
   assign rot_back = cfg.word_width - {1'b0, cfg.rotate_amount};
   assign rot_out  = ((rot_src << cfg.rotate_amount) | (rot_src >> rot_back)) & mask;

   always_comb begin
      stepped = state;
      if (cfg.eight_words) begin
         stepped[0] = s[0] ^ s[6];
         stepped[1] = r1;
         stepped[2] = r2;
         stepped[3] = r3;
         stepped[4] = r4;
         stepped[5] = r5;
         stepped[6] = r6 ^ t;
         stepped[7] = rot_out;
      end else begin
         stepped[0] = s[0] ^ r3;
         stepped[1] = r1;
         stepped[2] = r2 ^ t;
         stepped[3] = rot_out;
      end
   end

   always_comb begin
      next_state = state;
      if (cmd_load) begin
         next_state[word_index] = seed_word & mask;
      end else if (!config_error) begin
         next_state = stepped;
      end
      for (int i = 0; i < xst_pkg::NUM_WORDS; i++) begin
         result_words[i] = next_state[i] & mask;
      end
   end

endmodule

`default_nettype wire

@@ hdl/xoshiro_state_transition_unit.sv @@
// ----------------------------------------------------------------------------
// xoshiro_state_transition_unit
// Xoshiro linear state engine with configurable word width and word count.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the req_ channel either loads one seed word (command one)
//   into the word picked by req_word_index, or advances the engine by one
//   four-word or eight-word xoshiro step (command zero). Every request
//   returns one response on the rsp_ channel with all eight state words,
//   masked to the configured width, and a flag for an invalid width, shift
//   or rotation; with an invalid setup a step leaves the state alone while
//   a load still goes through. One request is taken per cycle unless req_stall
//   is high: the update is one pass of xor, shift and rotate logic between
//   the request register and the state and response registers. A stalled
//   response holds its payload, and req_stall is high only while the request
//   register is full and a response waits under rsp_stall. Reset clears the
//   words, empties both stages and restores width 64, four-word mode, shift
//   17 and rotation 45. The user must write the csr_ port only while the
//   block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module xoshiro_state_transition_unit (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic [xst_pkg::INDEX_BITS-1:0]      req_word_index,
   input  logic [xst_pkg::WORD_BITS-1:0]       req_seed_word,
   // Response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [xst_pkg::WORD_BITS-1:0]       rsp_state_word_0,
   output logic [xst_pkg::WORD_BITS-1:0]       rsp_state_word_1,
   output logic [xst_pkg::WORD_BITS-1:0]       rsp_state_word_2,
   output logic [xst_pkg::WORD_BITS-1:0]       rsp_state_word_3,
   output logic [xst_pkg::WORD_BITS-1:0]       rsp_state_word_4,
   output logic [xst_pkg::WORD_BITS-1:0]       rsp_state_word_5,
   output logic [xst_pkg::WORD_BITS-1:0]       rsp_state_word_6,
   output logic [xst_pkg::WORD_BITS-1:0]       rsp_state_word_7,
   output logic                                rsp_config_error,
   // Configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [xst_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [xst_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [xst_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);

   xst_pkg::cfg_type                  cfg;

   // Request register stage.
   logic                              in_valid_ff;
   logic                              in_valid_in;
   logic                              in_command_ff;
   logic [xst_pkg::INDEX_BITS-1:0]    in_word_index_ff;
   xst_pkg::word_type                 in_seed_word_ff;

   // Engine state and response register.
   xst_pkg::words_type                engine_words_ff;
   xst_pkg::words_type                engine_words_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   xst_pkg::words_type                rsp_words_ff;
   logic                              rsp_error_ff;

   xst_pkg::words_type                result_words;
   logic                              config_error;
   logic                              out_free;
   logic                              fire;
   logic                              req_accept;
   logic                              cmd_load;

   xst_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign cmd_load = (xst_pkg::command_type'(in_command_ff) == xst_pkg::CMD_LOAD);

   xst_update u_update (
      .cfg          (cfg),
      .cmd_load     (cmd_load),
      .word_index   (in_word_index_ff),
      .seed_word    (in_seed_word_ff),
      .state        (engine_words_ff),
      .next_state   (engine_words_in),
      .result_words (result_words),
      .config_error (config_error)
   );

   // The response register can take a new result when it is empty or when
   // its current result leaves in this cycle.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign fire       = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         engine_words_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            engine_words_ff <= engine_words_in;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_command_ff    <= req_command;
         in_word_index_ff <= req_word_index;
         in_seed_word_ff  <= req_seed_word;
      end
      if (fire) begin
         rsp_words_ff <= result_words;
         rsp_error_ff <= config_error;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_state_word_0 = rsp_words_ff[0];
   assign rsp_state_word_1 = rsp_words_ff[1];
   assign rsp_state_word_2 = rsp_words_ff[2];
   assign rsp_state_word_3 = rsp_words_ff[3];
   assign rsp_state_word_4 = rsp_words_ff[4];
   assign rsp_state_word_5 = rsp_words_ff[5];
   assign rsp_state_word_6 = rsp_words_ff[6];
   assign rsp_state_word_7 = rsp_words_ff[7];
   assign rsp_config_error = rsp_error_ff;

endmodule

`default_nettype wire

@@ hdl/xst_checker.sv @@
// ----------------------------------------------------------------------------
// xst_checker
// Port-level checks for the xoshiro state transition unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xoshiro_state_transition_unit_defines.svh"

module xst_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_stall,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [xst_pkg::WORD_BITS-1:0]   rsp_state_word_0,
   input  logic                            rsp_config_error
);

   logic [xst_pkg::WORD_BITS:0] rsp_payload;

   assign rsp_payload = {rsp_config_error, rsp_state_word_0};

   // A stalled response stays valid.
   `XST_ASSERT_NEXT(a_rsp_hold_valid, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // A stalled response keeps its payload.
   `XST_ASSERT_NEXT(a_rsp_hold_data, clock, reset, rsp_valid && rsp_stall, $stable(rsp_payload))

   // Requests are only held off while a response is waiting and blocked.
   `XST_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // Both stages come out of reset empty.
   `XST_ASSERT_NOW(a_reset_empty, clock, reset, $past(reset), !rsp_valid && !req_stall)

endmodule

bind xoshiro_state_transition_unit xst_checker u_xst_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_state_word_0 (rsp_state_word_0),
   .rsp_config_error (rsp_config_error)
);

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the xoshiro state transition unit
// Directed and random load and step requests under several word widths,
// word counts, shift and rotation settings, checked against an in-bench
// prediction of the state words and the configuration error flag.
// ----------------------------------------------------------------------------
module testbench;

   // A generous bound on cycles without any transfer on any port.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_COUNT    = 14;
   localparam int PHASE_REQUESTS = 50;
   localparam int DRAIN_CYCLES   = 10;

   // One response as the checker sees it: all eight words plus the flag.
   typedef struct packed {
      xst_pkg::words_type words;
      logic               config_error;
   } report_type;

   typedef enum logic {
      ROW_REQUEST,
      ROW_CSR
   } row_kind_type;

   // One line of the directed stimulus table. A row with fixed set carries
   // its response typed in; all other rows rely on the predictor.
   typedef struct {
      row_kind_type                      kind;
      xst_pkg::command_type              command;
      logic [xst_pkg::INDEX_BITS-1:0]    word_index;
      xst_pkg::word_type                 seed;
      xst_pkg::csr_index_type            csr_index;
      logic [xst_pkg::CSR_DATA_BITS-1:0] csr_value;
      bit                                fixed;
      report_type                        fixed_report;
   } plan_row_type;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   xst_pkg::command_type              req_command;
   logic [xst_pkg::INDEX_BITS-1:0]    req_word_index;
   xst_pkg::word_type                 req_seed_word;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   xst_pkg::word_type                 rsp_state_word_0;
   xst_pkg::word_type                 rsp_state_word_1;
   xst_pkg::word_type                 rsp_state_word_2;
   xst_pkg::word_type                 rsp_state_word_3;
   xst_pkg::word_type                 rsp_state_word_4;
   xst_pkg::word_type                 rsp_state_word_5;
   xst_pkg::word_type                 rsp_state_word_6;
   xst_pkg::word_type                 rsp_state_word_7;
   logic                              rsp_config_error;
   logic                              csr_psel;
   logic                              csr_penable;
   logic                              csr_pwrite;
   logic [xst_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [xst_pkg::CSR_DATA_BITS-1:0] csr_pwdata;
   logic [xst_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                              csr_pready;

   // Shadow copy of the engine words and of the register file.
   xst_pkg::word_type shadow_words [xst_pkg::NUM_WORDS];
   xst_pkg::cfg_type  shadow_cfg;
   // Responses predicted for accepted requests, oldest first.
   report_type        pending_reports [$];
   plan_row_type      directed_plan [$];
   int                mismatch_count = 0;
   // Random idling of both sides is allowed while this is set.
   bit                idle_on = 1'b1;
   int                stall_left = 0;
   int                quiet_cycles = 0;

   xoshiro_state_transition_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_word_index   (req_word_index),
      .req_seed_word    (req_seed_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_state_word_0 (rsp_state_word_0),
      .rsp_state_word_1 (rsp_state_word_1),
      .rsp_state_word_2 (rsp_state_word_2),
      .rsp_state_word_3 (rsp_state_word_3),
      .rsp_state_word_4 (rsp_state_word_4),
      .rsp_state_word_5 (rsp_state_word_5),
      .rsp_state_word_6 (rsp_state_word_6),
      .rsp_state_word_7 (rsp_state_word_7),
      .rsp_config_error (rsp_config_error),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   always #5 clock = ~clock;

   // Computes the response to one request and moves the shadow state on.
   // A load always lands, masked to the current width. A step runs only when
   // the width lies in 1..64 and both amounts lie in 1..width-1; it reads the
   // words through the mask, so stale bits above a shrunk width drop out.
   function automatic report_type predict_report(xst_pkg::command_type cmd,
                                                 logic [xst_pkg::INDEX_BITS-1:0] idx,
                                                 xst_pkg::word_type seed);
      xst_pkg::word_type m;
      xst_pkg::word_type t;
      xst_pkg::word_type s [xst_pkg::NUM_WORDS];
      int                w;
      int                sh;
      int                b;
      bit                bad;
      report_type        r;
      w  = shadow_cfg.word_width;
      sh = shadow_cfg.shift_amount;
      b  = shadow_cfg.rotate_amount;
      // Widths above 64 saturate the mask; width zero masks everything off.
      if (w >= xst_pkg::WORD_BITS)
         m = '1;
      else if (w == 0)
         m = '0;
      else
         m = (xst_pkg::word_type'(1) << w) - xst_pkg::word_type'(1);
      bad = (w == 0) || (w > xst_pkg::WORD_BITS) || (sh < 1) || (sh > w - 1) ||
            (b < 1) || (b > w - 1);
      if (cmd == xst_pkg::CMD_LOAD) begin
         shadow_words[idx] = seed & m;
      end else if (!bad) begin
         for (int i = 0; i < xst_pkg::NUM_WORDS; i++)
            s[i] = shadow_words[i] & m;
         t = (s[1] << sh) & m;
         if (!shadow_cfg.eight_words) begin
            s[2] ^= s[0];
            s[3] ^= s[1];
            s[1] ^= s[2];
            s[0] ^= s[3];
            s[2] ^= t;
            s[3] = ((s[3] << b) | (s[3] >> (w - b))) & m;
            // Words four to seven keep their stored value in this mode.
            for (int i = 0; i < xst_pkg::FOUR_WORDS; i++)
               shadow_words[i] = s[i] & m;
         end else begin
            s[2] ^= s[0];
            s[5] ^= s[1];
            s[1] ^= s[2];
            s[7] ^= s[3];
            s[3] ^= s[4];
            s[4] ^= s[5];
            s[0] ^= s[6];
            s[6] ^= s[7];
            s[6] ^= t;
            s[7] = ((s[7] << b) | (s[7] >> (w - b))) & m;
            for (int i = 0; i < xst_pkg::NUM_WORDS; i++)
               shadow_words[i] = s[i] & m;
         end
      end
      for (int i = 0; i < xst_pkg::NUM_WORDS; i++)
         r.words[i] = shadow_words[i] & m;
      r.config_error = bad;
      return r;
   endfunction

   // Seeds lean toward all zeros, all ones and single bits now and then.
   function automatic xst_pkg::word_type random_seed();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return xst_pkg::word_type'(1) << $urandom_range(0, xst_pkg::WORD_BITS - 1);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // A response in which only one word is set, for the typed-in rows.
   function automatic report_type single_word(int idx, xst_pkg::word_type value,
                                              logic flag);
      report_type r;
      r = '0;
      r.words[idx] = value;
      r.config_error = flag;
      return r;
   endfunction

   function automatic void add_request(xst_pkg::command_type cmd, int idx,
                                       xst_pkg::word_type seed);
      plan_row_type row;
      row = '{kind: ROW_REQUEST, command: cmd,
              word_index: xst_pkg::INDEX_BITS'(idx), seed: seed,
              csr_index: xst_pkg::REG_WORD_WIDTH, csr_value: '0, fixed: 1'b0,
              fixed_report: '0};
      directed_plan = {directed_plan, row};
   endfunction

   function automatic void add_fixed(xst_pkg::command_type cmd, int idx,
                                     xst_pkg::word_type seed, report_type report);
      plan_row_type row;
      row = '{kind: ROW_REQUEST, command: cmd,
              word_index: xst_pkg::INDEX_BITS'(idx), seed: seed,
              csr_index: xst_pkg::REG_WORD_WIDTH, csr_value: '0, fixed: 1'b1,
              fixed_report: report};
      directed_plan = {directed_plan, row};
   endfunction

   function automatic void add_csr(xst_pkg::csr_index_type sel, int value);
      plan_row_type row;
      row = '{kind: ROW_CSR, command: xst_pkg::CMD_STEP, word_index: '0, seed: '0,
              csr_index: sel, csr_value: value, fixed: 1'b0, fixed_report: '0};
      directed_plan = {directed_plan, row};
   endfunction

   // Presents one request, holds it until it is taken and then records its
   // expected response. Entered and left at a falling edge. The valid stays
   // high on exit so that back-to-back requests need no extra assignment.
   task automatic send_request(xst_pkg::command_type cmd,
                               logic [xst_pkg::INDEX_BITS-1:0] idx,
                               xst_pkg::word_type seed, bit fixed,
                               report_type fixed_report);
      report_type predicted;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_word_index <= idx;
      req_seed_word  <= seed;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = predict_report(cmd, idx, seed);
      pending_reports = {pending_reports, (fixed ? fixed_report : predicted)};
      @(negedge clock);
   endtask

   // Lets every outstanding response come back; the block is idle after.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_reports.size() != 0)
         @(negedge clock);
   endtask

   // Writes one register with junk above its field, then reads it back.
   // Only the field bits of the read data are compared. The port is left
   // idle before the task returns so that the next access starts at a later edge.
   task automatic csr_write(xst_pkg::csr_index_type sel,
                            logic [xst_pkg::CSR_DATA_BITS-1:0] value);
      logic [xst_pkg::CSR_DATA_BITS-1:0] field_mask;
      case (sel)
         xst_pkg::REG_WORD_WIDTH: begin
            field_mask = (1 << xst_pkg::WIDTH_BITS) - 1;
            shadow_cfg.word_width = value[xst_pkg::WIDTH_BITS-1:0];
         end
         xst_pkg::REG_EIGHT_WORDS: begin
            field_mask = 1;
            shadow_cfg.eight_words = value[0];
         end
         xst_pkg::REG_SHIFT_AMOUNT: begin
            field_mask = (1 << xst_pkg::AMOUNT_BITS) - 1;
            shadow_cfg.shift_amount = value[xst_pkg::AMOUNT_BITS-1:0];
         end
         default: begin
            field_mask = (1 << xst_pkg::AMOUNT_BITS) - 1;
            shadow_cfg.rotate_amount = value[xst_pkg::AMOUNT_BITS-1:0];
         end
      endcase
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= (value & field_mask) | ($urandom & ~field_mask);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if ((csr_prdata & field_mask) !== (value & field_mask)) begin
         $display("%0t: register %s read back: expected %h, actual %h", $time,
                  sel.name(), value & field_mask, csr_prdata & field_mask);
         mismatch_count++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Response checker: every accepted response is matched word by word and
   // flag by flag against the oldest prediction.
   always @(posedge clock) begin
      report_type seen;
      report_type wanted;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         seen.words = {rsp_state_word_7, rsp_state_word_6, rsp_state_word_5,
                       rsp_state_word_4, rsp_state_word_3, rsp_state_word_2,
                       rsp_state_word_1, rsp_state_word_0};
         seen.config_error = rsp_config_error;
         if (pending_reports.size() == 0) begin
            $display("%0t: response with no request outstanding: expected none, actual %h",
                     $time, seen);
            mismatch_count++;
         end else begin
            wanted = pending_reports.pop_front();
            for (int i = 0; i < xst_pkg::NUM_WORDS; i++) begin
               if (seen.words[i] !== wanted.words[i]) begin
                  $display("%0t: state word %0d: expected %h, actual %h", $time, i,
                           wanted.words[i], seen.words[i]);
                  mismatch_count++;
               end
            end
            if (seen.config_error !== wanted.config_error) begin
               $display("%0t: config error flag: expected %b, actual %b", $time,
                        wanted.config_error, seen.config_error);
               mismatch_count++;
            end
         end
      end
   end

   // Response back-pressure comes in random bursts, and only
   // while idling is allowed.
   always @(negedge clock) begin
      if (reset || !idle_on) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: any transfer on any port counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int width;
      int top;
      int sent;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_command    = xst_pkg::CMD_STEP;
      req_word_index = '0;
      req_seed_word  = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      for (int i = 0; i < xst_pkg::NUM_WORDS; i++)
         shadow_words[i] = '0;
      shadow_cfg = '{word_width: xst_pkg::WIDTH_RESET, eight_words: xst_pkg::EIGHT_RESET,
                     shift_amount: xst_pkg::SHIFT_RESET,
                     rotate_amount: xst_pkg::ROTATE_RESET};
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Straight out of reset the words are zero, so a step keeps them zero
      // and single loads show up alone.
      add_fixed(xst_pkg::CMD_STEP, 0, '0, single_word(0, '0, 1'b0));
      add_fixed(xst_pkg::CMD_LOAD, 0, '1, single_word(0, '1, 1'b0));
      add_request(xst_pkg::CMD_LOAD, 0, 64'h0123_4567_89AB_CDEF);
      add_request(xst_pkg::CMD_LOAD, 1, 64'hFEDC_BA98_7654_3210);
      add_request(xst_pkg::CMD_LOAD, 2, 64'h8000_0000_0000_0001);
      add_request(xst_pkg::CMD_LOAD, 3, '1);
      // Word seven must ride through four-word steps untouched.
      add_request(xst_pkg::CMD_LOAD, 7, 64'hA5A5_5A5A_C3C3_3C3C);
      add_request(xst_pkg::CMD_STEP, 7, '1);
      add_request(xst_pkg::CMD_STEP, 0, '0);
      add_csr(xst_pkg::REG_EIGHT_WORDS, 1);
      add_request(xst_pkg::CMD_LOAD, 5, 64'h0000_0000_FFFF_FFFF);
      add_request(xst_pkg::CMD_STEP, 5, '0);
      add_request(xst_pkg::CMD_STEP, 2, '0);
      // Largest and smallest legal amounts at full width.
      add_csr(xst_pkg::REG_SHIFT_AMOUNT, 63);
      add_csr(xst_pkg::REG_ROTATE_AMOUNT, 63);
      add_request(xst_pkg::CMD_STEP, 0, '0);
      add_csr(xst_pkg::REG_SHIFT_AMOUNT, 1);
      add_csr(xst_pkg::REG_ROTATE_AMOUNT, 1);
      add_request(xst_pkg::CMD_STEP, 0, '0);
      // Width one can never hold a legal amount, so the step is refused.
      add_csr(xst_pkg::REG_WORD_WIDTH, 1);
      add_request(xst_pkg::CMD_STEP, 0, '0);
      // Width zero masks every word to zero and flags the setup.
      add_csr(xst_pkg::REG_WORD_WIDTH, 0);
      add_fixed(xst_pkg::CMD_LOAD, 4, '1, single_word(4, '0, 1'b1));
      add_fixed(xst_pkg::CMD_STEP, 0, '0, single_word(0, '0, 1'b1));
      // Widths above 64 keep the full mask but are still illegal.
      add_csr(xst_pkg::REG_WORD_WIDTH, 127);
      add_request(xst_pkg::CMD_STEP, 0, '0);
      add_request(xst_pkg::CMD_LOAD, 6, '1);
      // Narrowest legal engine; the stored upper bits stay behind the mask.
      add_csr(xst_pkg::REG_WORD_WIDTH, 2);
      add_request(xst_pkg::CMD_STEP, 0, '0);
      add_request(xst_pkg::CMD_LOAD, 3, '1);
      add_request(xst_pkg::CMD_STEP, 0, '0);
      // Zero shift and zero rotation are each illegal on their own.
      add_csr(xst_pkg::REG_WORD_WIDTH, 64);
      add_csr(xst_pkg::REG_SHIFT_AMOUNT, 0);
      add_request(xst_pkg::CMD_STEP, 0, '0);
      add_csr(xst_pkg::REG_SHIFT_AMOUNT, 17);
      add_csr(xst_pkg::REG_ROTATE_AMOUNT, 0);
      add_request(xst_pkg::CMD_STEP, 0, '0);
      add_csr(xst_pkg::REG_ROTATE_AMOUNT, 45);
      add_csr(xst_pkg::REG_EIGHT_WORDS, 0);
      add_csr(xst_pkg::REG_WORD_WIDTH, 33);
      add_request(xst_pkg::CMD_STEP, 0, '0);

      foreach (directed_plan[n]) begin
         if (directed_plan[n].kind == ROW_CSR) begin
            wait_drained();
            csr_write(directed_plan[n].csr_index, directed_plan[n].csr_value);
         end else begin
            send_request(directed_plan[n].command, directed_plan[n].word_index,
                         directed_plan[n].seed, directed_plan[n].fixed,
                         directed_plan[n].fixed_report);
         end
      end

      // Random phases: a fresh setting, usually a full reseed, then a long
      // run of steps with the odd stray load. The last phase runs without
      // any idling on either side.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_drained();
         idle_on = (p < PHASE_COUNT - 1) && ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0, 1, 2, 3: width = xst_pkg::WORD_BITS;
            4:          width = $urandom_range(0, (1 << xst_pkg::WIDTH_BITS) - 1);
            default:    width = $urandom_range(2, xst_pkg::WORD_BITS);
         endcase
         top = (width < 2) ? 0 :
               (width > xst_pkg::WORD_BITS) ? xst_pkg::WORD_BITS - 1 : width - 1;
         csr_write(xst_pkg::REG_WORD_WIDTH, width);
         csr_write(xst_pkg::REG_EIGHT_WORDS, $urandom_range(0, 1));
         csr_write(xst_pkg::REG_SHIFT_AMOUNT, (top > 0 && $urandom_range(0, 7) != 0) ?
                   $urandom_range(1, top) :
                   $urandom_range(0, (1 << xst_pkg::AMOUNT_BITS) - 1));
         csr_write(xst_pkg::REG_ROTATE_AMOUNT, (top > 0 && $urandom_range(0, 7) != 0) ?
                   $urandom_range(1, top) :
                   $urandom_range(0, (1 << xst_pkg::AMOUNT_BITS) - 1));
         sent = 0;
         if ($urandom_range(0, 3) != 0) begin
            for (int i = 0; i < xst_pkg::NUM_WORDS; i++) begin
               send_request(xst_pkg::CMD_LOAD, xst_pkg::INDEX_BITS'(i), random_seed(),
                            1'b0, '0);
               sent++;
            end
         end
         while (sent < PHASE_REQUESTS) begin
            // Steps carry random index and seed bits that must be ignored.
            if ($urandom_range(0, 6) == 0)
               send_request(xst_pkg::CMD_LOAD, xst_pkg::INDEX_BITS'($urandom),
                            random_seed(), 1'b0, '0);
            else
               send_request(xst_pkg::CMD_STEP, xst_pkg::INDEX_BITS'($urandom),
                            random_seed(), 1'b0, '0);
            sent++;
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/xst_pkg.sv
hdl/xst_csr.sv
hdl/xst_update.sv
hdl/xoshiro_state_transition_unit.sv
hdl/xst_checker.sv
verif/testbench.sv
